// ----- rtl/sed_pkg.sv -----
// Shared types and constants for the STX/ETX response deframer.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package sed_pkg;

  // Framing bytes and limits.
  localparam logic [7:0] STX_BYTE        = 8'h02;
  localparam logic [7:0] ETX_BYTE        = 8'h03;
  localparam int         MAX_FRAME_BYTES = 64;
  localparam int         CNT_W           = 7;
  localparam int         MIN_DATA_BYTES  = 4;

  // Response command numbers.
  localparam logic [7:0] CMD_RETRANSMIT  = 8'd100;
  localparam logic [7:0] CMD_MOVE_DONE   = 8'd101;
  localparam logic [7:0] CMD_AUTO_REBOOT = 8'd111;
  localparam logic [7:0] CMD_SHUTDOWN    = 8'd200;
  localparam logic [7:0] CMD_LCD         = 8'd91;

  // Depth of the record queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SUM   = 2'd1,
    ST_TOO_SHORT = 2'd2,
    ST_TOO_LONG  = 2'd3
  } frame_status_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_RETRANSMIT  = 3'd1,
    EV_MOVE_OK     = 3'd2,
    EV_AUTO_REBOOT = 3'd3,
    EV_SHUTDOWN    = 3'd4,
    EV_LCD_ON      = 3'd5,
    EV_LCD_OFF     = 3'd6
  } event_code_t;

  // One closed frame as classified by the front part.
  typedef struct packed {
    logic [7:0]    bed_id;
    logic [7:0]    command_code;
    logic [7:0]    response_value;
    frame_status_t status;
  } frame_rec_t;

  // One finished result word.
  typedef struct packed {
    frame_status_t frame_status;
    event_code_t   event_code;
    logic [7:0]    response_value;
    logic [7:0]    command_code;
    logic [7:0]    bed_id;
  } result_t;

  // Handshake between the record queue and its consumer.
  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/sed_front.sv -----
// Front part: takes received bytes, tracks the frame and classifies it at the end byte.
// Depends on sed_pkg.
`default_nettype none

module sed_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [7:0]          in_tdata,
  input  wire                 q_full,
  output logic                rec_push,
  output sed_pkg::frame_rec_t rec_data
);
  import sed_pkg::*;

  localparam logic [CNT_W-1:0] MAX_DATA = CNT_W'(MAX_FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] OVF_MARK = CNT_W'(MAX_FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] MIN_DATA = CNT_W'(MIN_DATA_BYTES);

  logic             read_enable_r;
  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_inc;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [7:0]       bed_r, bed_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       resp_r, resp_nxt;
  logic             accept;

  assign in_tready = read_enable_r & ~q_full;
  assign accept    = in_tvalid & in_tready;
  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    last_nxt     = last_r;
    bed_nxt      = bed_r;
    cmd_nxt      = cmd_r;
    resp_nxt     = resp_r;
    rec_push     = 1'b0;
    if (accept) begin
      if (!in_frame_r) begin
        if (in_tdata == STX_BYTE) begin
          in_frame_nxt = 1'b1;
          count_nxt    = '0;
          sum_nxt      = '0;
          last_nxt     = '0;
          bed_nxt      = '0;
          cmd_nxt      = '0;
          resp_nxt     = '0;
        end
      end else if (in_tdata != ETX_BYTE) begin
        if (count_r >= MAX_DATA) begin
          // Overflowing bytes are dropped; the count parks on the overflow mark.
          count_nxt = OVF_MARK;
        end else begin
          sum_nxt   = sum_r + last_r;
          last_nxt  = in_tdata;
          count_nxt = count_inc;
          if (count_inc == CNT_W'(1)) bed_nxt  = in_tdata;
          if (count_inc == CNT_W'(2)) cmd_nxt  = in_tdata;
          if (count_inc == CNT_W'(3)) resp_nxt = in_tdata;
        end
      end else begin
        rec_push     = 1'b1;
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
      end
    end
  end

  always_comb begin
    rec_data.bed_id         = bed_r;
    rec_data.command_code   = cmd_r;
    rec_data.response_value = resp_r;
    priority if (count_r >= OVF_MARK) begin
      rec_data.status = ST_TOO_LONG;
    end else if (count_r < MIN_DATA) begin
      rec_data.status = ST_TOO_SHORT;
    end else if (sum_r != last_r) begin
      rec_data.status = ST_BAD_SUM;
    end else begin
      rec_data.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_enable_r <= 1'b1;
      in_frame_r    <= 1'b0;
      count_r       <= '0;
      sum_r         <= '0;
      last_r        <= '0;
      bed_r         <= '0;
      cmd_r         <= '0;
      resp_r        <= '0;
    end else begin
      if (cfg_wr_en) read_enable_r <= cfg_wr_data;
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      last_r     <= last_nxt;
      bed_r      <= bed_nxt;
      cmd_r      <= cmd_nxt;
      resp_r     <= resp_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sed_queue.sv -----
// Short record queue that decouples the front and back parts.
// Depends on sed_pkg.
`default_nettype none

module sed_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire  sed_pkg::frame_rec_t push_data,
  input  wire                    pop,
  output sed_pkg::frame_rec_t    pop_data,
  output sed_pkg::queue_status_t q_stat
);
  import sed_pkg::*;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  frame_rec_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & q_stat.valid;
  assign pop_data     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + QPTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + QPTR_W'(1);
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sed_back.sv -----
// Back part: decodes the event of a good frame and holds the result word for the output.
// Depends on sed_pkg.
`default_nettype none

module sed_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  sed_pkg::queue_status_t q_stat,
  input  wire  sed_pkg::frame_rec_t    rec_data,
  output logic                   rec_pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output sed_pkg::result_t       out_word
);
  import sed_pkg::*;

  logic        valid_r;
  result_t     word_r, word_nxt;
  event_code_t ev;

  always_comb begin
    ev = EV_NONE;
    if (rec_data.status == ST_OK) begin
      unique case (rec_data.command_code)
        CMD_RETRANSMIT:  ev = EV_RETRANSMIT;
        CMD_MOVE_DONE:   ev = EV_MOVE_OK;
        CMD_AUTO_REBOOT: ev = EV_AUTO_REBOOT;
        CMD_SHUTDOWN:    ev = EV_SHUTDOWN;
        CMD_LCD:         ev = (rec_data.response_value != 8'd0) ? EV_LCD_ON : EV_LCD_OFF;
        default:         ev = EV_NONE;
      endcase
    end
  end

  always_comb begin
    word_nxt.bed_id         = rec_data.bed_id;
    word_nxt.command_code   = rec_data.command_code;
    word_nxt.response_value = rec_data.response_value;
    word_nxt.event_code     = ev;
    word_nxt.frame_status   = rec_data.status;
  end

  // The output register reloads whenever a record is waiting and it is empty or being drained.
  assign rec_pop   = q_stat.valid & (~valid_r | out_ready);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (rec_pop) word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stx_etx_response_deframer.sv -----
// Path: the end byte's record is written into the queue when the byte is taken, and its
// result word is loaded from the queue head into the output register once that is free.
// Throughput: one byte word per cycle; a two-record queue and the output register absorb
// output stalls, and input ready drops only when both are full or read_enable is 0.
// Reset: synchronous, active low; read_enable returns to 1, the block hunts for a start
// byte and the queue and output are emptied.
`default_nettype none

module stx_etx_response_deframer (
  input  wire         clk,
  input  wire         rst_n,
  // Configuration: read_enable register.
  input  wire         cfg_wr_en,
  input  wire         cfg_wr_data,
  // Received bytes.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  // Response results.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata   // [7:0] bed_id, [15:8] command_code,
                                  // [23:16] response_value, [26:24] event_code,
                                  // [28:27] frame_status, [31:29] zero
);
  import sed_pkg::*;

  frame_rec_t    push_rec;
  frame_rec_t    head_rec;
  queue_status_t q_stat;
  logic          rec_push;
  logic          rec_pop;
  result_t       res_word;

  // The front part follows the byte stream and, at each end byte that closes a frame,
  // pushes one classified frame record (held bytes and status) into the queue.
  sed_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .q_full      (q_stat.full),
    .rec_push    (rec_push),
    .rec_data    (push_rec)
  );

  // The queue lets a stalled output leave byte intake running for a while.
  sed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (push_rec),
    .pop       (rec_pop),
    .pop_data  (head_rec),
    .q_stat    (q_stat)
  );

  // The back part decodes the event of good frames and drives the output word.
  sed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .rec_data  (head_rec),
    .rec_pop   (rec_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (res_word)
  );

  // The result word is 29 bits wide; the top bits of the bus are zero.
  assign out_tdata = {3'b000, res_word};

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stx_etx_response_deframer: byte words in, response words out,
// each response predicted by a small scoreboard class and compared field by field.
// Depends on rtl/sed_pkg.sv and rtl/stx_etx_response_deframer.sv.

module tb_top;
  import sed_pkg::*;

  localparam int CLK_HALF       = 2;
  // The result word of an end byte passes through the record queue and the output
  // register; the settle wait makes sure the block has gone quiet.
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int TARGET_WORDS   = 1250;
  localparam int MAX_DATA_BYTES = MAX_FRAME_BYTES - 2;

  // Scoreboard: mirrors the deframer state, builds the response word that each
  // end byte should produce and checks what the block actually returns.
  class response_scoreboard;
    bit               read_en;
    bit               collecting;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       running_sum;
    logic [7:0]       last_data;
    logic [7:0]       bed;
    logic [7:0]       cmd;
    logic [7:0]       resp;
    result_t          expected_responses[$];
    int               mismatches;
    int               responses_checked;
    int               status_seen[4];

    function new();
      read_en    = 1'b1;
      collecting = 1'b0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count  = '0;
      running_sum = '0;
      last_data   = '0;
      bed         = '0;
      cmd         = '0;
      resp        = '0;
    endfunction

    function void set_read_enable(bit value);
      read_en = value;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    function event_code_t event_for(logic [7:0] command, logic [7:0] response);
      case (command)
        CMD_RETRANSMIT:  return EV_RETRANSMIT;
        CMD_MOVE_DONE:   return EV_MOVE_OK;
        CMD_AUTO_REBOOT: return EV_AUTO_REBOOT;
        CMD_SHUTDOWN:    return EV_SHUTDOWN;
        CMD_LCD:         return (response != 8'h00) ? EV_LCD_ON : EV_LCD_OFF;
        default:         return EV_NONE;
      endcase
    endfunction

    // Called for every byte word the block accepts.
    function void take_byte(logic [7:0] b);
      result_t r;
      if (!read_en) return;
      if (!collecting) begin
        if (b == STX_BYTE) begin
          collecting = 1'b1;
          clear_frame();
        end
        return;
      end
      if (b != ETX_BYTE) begin
        // Past the data limit the byte is dropped and the count parks on the
        // overflow mark.
        if (byte_count >= MAX_DATA_BYTES) begin
          byte_count = CNT_W'(MAX_FRAME_BYTES - 1);
          return;
        end
        running_sum = running_sum + last_data;
        last_data   = b;
        byte_count  = byte_count + 1'b1;
        case (byte_count)
          1:       bed  = b;
          2:       cmd  = b;
          3:       resp = b;
          default: ;
        endcase
        return;
      end
      r                = '0;
      r.bed_id         = bed;
      r.command_code   = cmd;
      r.response_value = resp;
      r.event_code     = EV_NONE;
      if (byte_count >= MAX_FRAME_BYTES - 1)
        r.frame_status = ST_TOO_LONG;
      else if (byte_count < MIN_DATA_BYTES)
        r.frame_status = ST_TOO_SHORT;
      else if (running_sum != last_data)
        r.frame_status = ST_BAD_SUM;
      else begin
        r.frame_status = ST_OK;
        r.event_code   = event_for(cmd, resp);
      end
      expected_responses.push_back(r);
      status_seen[r.frame_status]++;
      collecting = 1'b0;
      byte_count = '0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t ns  MISMATCH  %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("response %0d: %s is %0d, predicted %0d",
                                  responses_checked, name, got, want));
    endtask

    // Called for every response word the block hands over.
    task check_word(logic [31:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[28:0]);
      responses_checked++;
      if (word[31:29] != 3'b000)
        report_mismatch($sformatf("response %0d: padding bits are %b",
                                  responses_checked, word[31:29]));
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with none predicted (word %h)",
                                  responses_checked, word));
        return;
      end
      want = expected_responses.pop_front();
      compare_field("bed_id", got.bed_id, want.bed_id);
      compare_field("command_code", got.command_code, want.command_code);
      compare_field("response_value", got.response_value, want.response_value);
      compare_field("event_code", got.event_code, want.event_code);
      compare_field("frame_status", got.frame_status, want.frame_status);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  response_scoreboard sb = new();

  // When a calm flag is set, that side runs with no idle cycles at all.
  bit         tx_calm;
  bit         rx_calm;
  // Words that belong to frames; hunting noise is not counted.
  int         words_sent;
  logic [7:0] pending_bytes[$];

  stx_etx_response_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // A generous ceiling that stops a hung run and reports it as an error.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Any byte except the end byte, so that a frame is not closed early.
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ETX_BYTE);
    return b;
  endfunction

  // Mostly the commands that carry an event, the rest anything.
  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 9))
      0:       return CMD_RETRANSMIT;
      1:       return CMD_MOVE_DONE;
      2:       return CMD_AUTO_REBOOT;
      3:       return CMD_SHUTDOWN;
      4, 5:    return CMD_LCD;
      default: return data_byte();
    endcase
  endfunction

  // Zero often enough that the LCD off case keeps turning up.
  function automatic logic [7:0] pick_response();
    return ($urandom_range(0, 4) == 0) ? 8'h00 : data_byte();
  endfunction

  // Offers one byte word and holds it until the block takes it. Inputs change
  // only on the falling edge, and tvalid stays high between back-to-back words.
  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.take_byte(b);
  endtask

  task automatic send_pending(input bit counts);
    while (pending_bytes.size() != 0) begin
      send_word(pending_bytes.pop_front());
      if (counts) words_sent++;
    end
  endtask

  // Queues a complete frame: start byte, bed, command, response, extra data,
  // the additive checksum (spoiled when bad_sum is set) and the end byte.
  task automatic push_frame(input logic [7:0] bed_byte, input logic [7:0] cmd_byte,
                            input logic [7:0] resp_byte, input int extra,
                            input bit bad_sum);
    logic [7:0] body[$];
    logic [7:0] sum;
    body = {bed_byte, cmd_byte, resp_byte};
    repeat (extra) body.push_back(data_byte());
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    pending_bytes.push_back(STX_BYTE);
    foreach (body[i]) pending_bytes.push_back(body[i]);
    pending_bytes.push_back(sum);
    pending_bytes.push_back(ETX_BYTE);
  endtask

  // Stops offering words and waits until every predicted response has come
  // back, then lets the block settle so a register write finds it idle.
  task automatic wait_idle();
    int waited;
    @(negedge clk);
    in_tvalid = 1'b0;
    waited    = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes read_enable. With the register cleared, input ready must stay low.
  task automatic set_read_enable(input bit value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_read_enable(value);
    if (!value) begin
      repeat (4) begin
        @(posedge clk);
        if (in_tready) sb.report_mismatch("in_tready is high while read_enable is 0");
      end
    end
  endtask

  // Result side: a random stall before each word, then ready until one is taken.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do begin
        @(posedge clk);
      end while (!out_tvalid);
      sb.check_word(out_tdata);
    end
  end

  initial begin
    int         phase;
    int         kind;
    logic [7:0] noise;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    words_sent  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_read_enable(1'b1);

    // While hunting, everything but a start byte is thrown away, an end byte too.
    pending_bytes = {8'h00, 8'hFF, ETX_BYTE, 8'h55};
    send_pending(1'b0);

    // One good frame for every event, with the field extremes spread across them.
    push_frame(8'h01, CMD_RETRANSMIT, 8'h10, 0, 1'b0);
    push_frame(8'hFF, CMD_MOVE_DONE, 8'hFF, 1, 1'b0);
    push_frame(8'h00, CMD_AUTO_REBOOT, 8'h00, 2, 1'b0);
    push_frame(8'h7E, CMD_SHUTDOWN, 8'h01, 0, 1'b0);
    push_frame(8'h20, CMD_LCD, 8'h01, 0, 1'b0);
    push_frame(8'h21, CMD_LCD, 8'h00, 0, 1'b0);
    push_frame(8'h22, 8'h00, 8'h00, 0, 1'b0);
    push_frame(8'h23, 8'hFF, 8'h80, 3, 1'b0);
    // Start bytes inside a frame are plain data, right after the opening one too.
    push_frame(STX_BYTE, STX_BYTE, STX_BYTE, 1, 1'b0);
    // A bad checksum must suppress the event.
    push_frame(8'h24, CMD_SHUTDOWN, 8'h05, 0, 1'b1);
    send_pending(1'b1);

    // Frames too short to hold a checksum: zero to three data bytes.
    pending_bytes = {STX_BYTE, ETX_BYTE,
                     STX_BYTE, 8'h11, ETX_BYTE,
                     STX_BYTE, 8'h12, CMD_RETRANSMIT, ETX_BYTE,
                     STX_BYTE, 8'h13, CMD_LCD, 8'h00, ETX_BYTE};
    send_pending(1'b1);

    // The longest legal frame, one byte more, and one far past the limit.
    push_frame(8'h30, CMD_MOVE_DONE, 8'h01, MAX_DATA_BYTES - 4, 1'b0);
    push_frame(8'h31, CMD_MOVE_DONE, 8'h01, MAX_DATA_BYTES - 3, 1'b0);
    push_frame(8'h32, CMD_LCD, 8'h00, MAX_DATA_BYTES + 20, 1'b1);
    send_pending(1'b1);

    // Turn reading off and back on in the middle of a frame; the partial frame
    // must survive. The checksum 0xA4 is 0x40 + 100 + 0x00.
    pending_bytes = {STX_BYTE, 8'h40, CMD_RETRANSMIT};
    send_pending(1'b1);
    wait_idle();
    set_read_enable(1'b0);
    set_read_enable(1'b1);
    pending_bytes = {8'h00, 8'hA4, ETX_BYTE};
    send_pending(1'b1);
    wait_idle();

    // Random part, in four phases: both sides idling, a sender with no gaps,
    // a receiver with no stalls, and both mixed again. Each phase ends with the
    // sender holding off until every predicted response is back.
    for (phase = 0; phase < 4; phase++) begin
      while (words_sent < TARGET_WORDS * (phase + 1) / 4) begin
        tx_calm = (phase == 1) || ($urandom_range(0, 3) == 0);
        rx_calm = (phase == 2) || ($urandom_range(0, 3) == 0);
        kind    = $urandom_range(0, 99);
        if (kind < 70) begin
          push_frame(data_byte(), pick_command(), pick_response(),
                     $urandom_range(0, 6), 1'b0);
        end else if (kind < 80) begin
          push_frame(data_byte(), pick_command(), pick_response(),
                     $urandom_range(0, 6), 1'b1);
        end else if (kind < 87) begin
          pending_bytes.push_back(STX_BYTE);
          repeat ($urandom_range(0, 3)) pending_bytes.push_back(data_byte());
          pending_bytes.push_back(ETX_BYTE);
        end else if (kind < 90) begin
          push_frame(data_byte(), pick_command(), pick_response(),
                     MAX_DATA_BYTES - 3 + $urandom_range(0, 12), $urandom_range(0, 1));
        end else if (kind < 95) begin
          // Line noise between frames; it does not count as frame traffic.
          repeat ($urandom_range(1, 6)) begin
            do noise = 8'($urandom); while (noise == STX_BYTE);
            pending_bytes.push_back(noise);
          end
          send_pending(1'b0);
          continue;
        end else begin
          // A broken frame: a start byte and raw bytes, end byte or not.
          pending_bytes.push_back(STX_BYTE);
          repeat ($urandom_range(0, 10)) pending_bytes.push_back(8'($urandom));
        end
        send_pending(1'b1);
      end
      wait_idle();
      if (phase == 1) begin
        set_read_enable(1'b0);
        set_read_enable(1'b1);
      end
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    wait_idle();
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d predicted responses never arrived", sb.pending()));

    $display("summary: %0d frame words sent, %0d response words checked",
             words_sent, sb.responses_checked);
    $display("summary: ok %0d, bad checksum %0d, too short %0d, too long %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_BAD_SUM],
             sb.status_seen[ST_TOO_SHORT], sb.status_seen[ST_TOO_LONG]);
    if (sb.mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sed_pkg.sv
rtl/sed_front.sv
rtl/sed_queue.sv
rtl/sed_back.sv
rtl/stx_etx_response_deframer.sv
verif/tb_top.sv
